// ===== hw/rtl/tcsw_pkg.sv =====
// Shared types and defaults for the text cell screen writer.
`default_nettype none
package tcsw_pkg;

	localparam int SCREEN_ROWS_DEF = 24;
	localparam int SCREEN_COLS_DEF = 80;

	localparam logic [7:0] BLANK_CHAR = 8'h20;

	// One result transfer
	typedef struct packed {
		logic [7:0] cell_char;
		logic [7:0] cell_attr;
		logic [4:0] cursor_row;
		logic [6:0] cursor_col;
	} res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/text_cell_screen_writer.sv =====
// Top level of the text cell screen writer: config register, output register, store.
`default_nettype none
// Character-cell screen store with a cursor. Each cell holds a character byte
// and an attribute byte (standout in bit 7, colour in bits 6..0). Commands come
// in one at a time on the in_* channel and every command returns one result
// transfer on the out_* channel: the cell read (reads only, else zero) and the
// cursor after the command. After reset the block blanks the whole store, one
// cell a cycle, before in_ready first rises; cfg_we writes are taken at any
// time. Afterwards a command goes from input transfer to result through these
// steps in order: capture, the shared address unit (row * cols + col), execute
// against the single-port store, and present the result. Clears walk the store
// through that same port at one cell per cycle, so clear to end of line covers
// up to SCREEN_COLS cells and clear to bottom or clear all up to
// SCREEN_ROWS*SCREEN_COLS cells. A finished result sits in the output register,
// so the next command can be taken while the previous result waits.
module text_cell_screen_writer #(
	parameter int SCREEN_ROWS = tcsw_pkg::SCREEN_ROWS_DEF,
	parameter int SCREEN_COLS = tcsw_pkg::SCREEN_COLS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [6:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [3:0] kind,
	input  wire logic [4:0] row,
	input  wire logic [6:0] col,
	input  wire logic [7:0] char_code,
	input  wire logic [6:0] color,
	input  wire logic       standout_on,
	input  wire logic       text_last,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      cell_char,
	output logic [7:0]      cell_attr,
	output logic [4:0]      cursor_row,
	output logic [6:0]      cursor_col
);

	localparam int CELLS  = SCREEN_ROWS * SCREEN_COLS;
	localparam int ADDR_W = $clog2(CELLS);

	logic [6:0]        default_color_q;
	logic              out_valid_q;
	tcsw_pkg::res_t    out_q;
	tcsw_pkg::res_t    res;
	logic              res_valid;
	logic              res_ready;
	logic              mem_we;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_addr;
	logic [15:0]       mem_wdata;
	logic [15:0]       mem_rdata;

	// Config: text colour, also restored as draw colour by text writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_color_q <= 7'd0;
		end else if (cfg_we) begin
			default_color_q <= cfg_wdata;
		end
	end

	// Output register: load when empty or being drained this cycle
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_char  = out_q.cell_char;
	assign cell_attr  = out_q.cell_attr;
	assign cursor_row = out_q.cursor_row;
	assign cursor_col = out_q.cursor_col;

	tcsw_ctrl #(
		.SCREEN_ROWS (SCREEN_ROWS),
		.SCREEN_COLS (SCREEN_COLS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.row           (row),
		.col           (col),
		.char_code     (char_code),
		.color         (color),
		.standout_on   (standout_on),
		.text_last     (text_last),
		.default_color (default_color_q),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res),
		.mem_we        (mem_we),
		.mem_re        (mem_re),
		.mem_addr      (mem_addr),
		.mem_wdata     (mem_wdata),
		.mem_rdata     (mem_rdata)
	);

	tcsw_mem #(
		.CELLS (CELLS)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.re      (mem_re),
		.addr    (mem_addr),
		.wdata   (mem_wdata),
		.rdata_q (mem_rdata)
	);

`ifndef ASSERT_OFF
	// The sequencer goes busy right after taking a command
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready still high after an input transfer");

	// Store writes only happen while a command or the reset sweep is running
	a_write_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !in_ready)
		else $error("store write while idle");

	// Every store access lands inside the screen
	a_addr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we || mem_re) |-> (int'(mem_addr) < CELLS))
		else $error("store address past the screen");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/tcsw_mem.sv =====
// Cell store: single address port, registered read data.
`default_nettype none
module tcsw_mem #(
	parameter int CELLS = tcsw_pkg::SCREEN_ROWS_DEF * tcsw_pkg::SCREEN_COLS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic                      re,
	input  wire logic [$clog2(CELLS)-1:0]  addr,
	input  wire logic [15:0]               wdata,
	output logic      [15:0]               rdata_q
);

	logic [15:0] mem_q [CELLS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/tcsw_ctrl.sv =====
// Command sequencer: cursor state, address unit and clear sweeps.
`default_nettype none
module tcsw_ctrl #(
	parameter int SCREEN_ROWS = tcsw_pkg::SCREEN_ROWS_DEF,
	parameter int SCREEN_COLS = tcsw_pkg::SCREEN_COLS_DEF,
	localparam int CELLS  = SCREEN_ROWS * SCREEN_COLS,
	localparam int ADDR_W = $clog2(CELLS),
	localparam int BASE_W = $clog2(CELLS + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [3:0]         kind,
	input  wire logic [4:0]         row,
	input  wire logic [6:0]         col,
	input  wire logic [7:0]         char_code,
	input  wire logic [6:0]         color,
	input  wire logic               standout_on,
	input  wire logic               text_last,
	input  wire logic [6:0]         default_color,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output tcsw_pkg::res_t          res,
	output logic                    mem_we,
	output logic                    mem_re,
	output logic [ADDR_W-1:0]       mem_addr,
	output logic [15:0]             mem_wdata,
	input  wire logic [15:0]        mem_rdata
);

	localparam logic [2:0] ST_INIT = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_ADDR = 3'd2;
	localparam logic [2:0] ST_EXEC = 3'd3;
	localparam logic [2:0] ST_CLR  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	localparam logic [3:0] K_MOVE  = 4'd0;
	localparam logic [3:0] K_GLYPH = 4'd1;
	localparam logic [3:0] K_TEXT  = 4'd2;
	localparam logic [3:0] K_COLOR = 4'd3;
	localparam logic [3:0] K_STAND = 4'd4;
	localparam logic [3:0] K_EOL   = 4'd5;
	localparam logic [3:0] K_BOT   = 4'd6;
	localparam logic [3:0] K_ALL   = 4'd7;
	localparam logic [3:0] K_READ  = 4'd8;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] ADDR_ONE  = ADDR_W'(1);
	localparam logic [6:0]        LAST_COL  = 7'(SCREEN_COLS - 1);

	logic [2:0]        state_q;
	logic [3:0]        kind_q;
	logic [4:0]        row_q;
	logic [6:0]        col_q;
	logic [7:0]        ch_q;
	logic [6:0]        color_q;
	logic              so_q;
	logic              last_q;
	logic [4:0]        cur_row_q;
	logic [6:0]        cur_col_q;
	logic              standout_q;
	logic [6:0]        draw_color_q;
	logic              stopped_q;
	logic [BASE_W-1:0] base_q;
	logic              row_ok_q;
	logic              col_ok_q;
	logic [ADDR_W-1:0] swp_addr_q;
	logic [6:0]        swp_col_q;
	logic              swp_full_q;

	logic [4:0]        r_sel;
	logic [6:0]        c_sel;
	logic              row_ok;
	logic              col_ok;
	logic [7:0]        c_add;
	logic [BASE_W-1:0] base;
	logic              col_adv;
	logic              swp_end;
	logic              wr_cell;
	logic [6:0]        wr_color;

	// Address unit: row * cols + column (or + cols when the column is off screen)
	always_comb begin
		r_sel  = (kind_q == K_READ) ? row_q : cur_row_q;
		c_sel  = (kind_q == K_READ) ? col_q : cur_col_q;
		row_ok = {1'b0, r_sel} < 6'(SCREEN_ROWS);
		col_ok = {1'b0, c_sel} < 8'(SCREEN_COLS);
		c_add  = col_ok ? {1'b0, c_sel} : 8'(SCREEN_COLS);
		base   = BASE_W'(BASE_W'(r_sel) * BASE_W'(SCREEN_COLS) + BASE_W'(c_add));
	end

	assign col_adv = {1'b0, cur_col_q} < 8'(SCREEN_COLS - 1);
	assign swp_end = swp_full_q ? (swp_addr_q == LAST_ADDR) : (swp_col_q == LAST_COL);

	always_comb begin
		wr_cell = 1'b0;
		if (state_q == ST_EXEC && row_ok_q && col_ok_q) begin
			wr_cell = (kind_q == K_GLYPH) || (kind_q == K_TEXT && !stopped_q);
		end
	end

	assign wr_color  = (kind_q == K_TEXT) ? default_color : draw_color_q;
	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_FIN);
	assign mem_we    = wr_cell || state_q == ST_CLR || state_q == ST_INIT;
	assign mem_re    = (state_q == ST_EXEC) && (kind_q == K_READ) && row_ok_q && col_ok_q;
	assign mem_addr  = (state_q == ST_CLR || state_q == ST_INIT) ? swp_addr_q
		: base_q[ADDR_W-1:0];
	assign mem_wdata = (state_q == ST_CLR || state_q == ST_INIT)
		? {8'h00, tcsw_pkg::BLANK_CHAR} : {standout_q, wr_color, ch_q};

	always_comb begin
		res.cell_char  = 8'h00;
		res.cell_attr  = 8'h00;
		res.cursor_row = cur_row_q;
		res.cursor_col = cur_col_q;
		if (kind_q == K_READ) begin
			if (row_ok_q && col_ok_q) begin
				res.cell_char = mem_rdata[7:0];
				res.cell_attr = mem_rdata[15:8];
			end else begin
				res.cell_char = tcsw_pkg::BLANK_CHAR;
			end
		end
	end

	// Item fields, captured on the input transfer; address unit results, registered in ST_ADDR
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_q  <= kind;
			row_q   <= row;
			col_q   <= col;
			ch_q    <= char_code;
			color_q <= color;
			so_q    <= standout_on;
			last_q  <= text_last;
		end
		if (state_q == ST_ADDR) begin
			base_q   <= base;
			row_ok_q <= row_ok;
			col_ok_q <= col_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			cur_row_q    <= 5'd0;
			cur_col_q    <= 7'd0;
			standout_q   <= 1'b0;
			draw_color_q <= 7'd0;
			stopped_q    <= 1'b0;
			swp_addr_q   <= '0;
			swp_col_q    <= 7'd0;
			swp_full_q   <= 1'b1;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					swp_addr_q <= swp_addr_q + ADDR_ONE;
					if (swp_addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_FIN;
					if (kind_q != K_TEXT) begin
						stopped_q <= 1'b0;
					end
					unique case (kind_q)
						K_MOVE: begin
							cur_row_q <= row_q;
							cur_col_q <= col_q;
						end
						K_GLYPH: begin
							if (col_adv) begin
								cur_col_q <= cur_col_q + 7'd1;
							end
						end
						K_TEXT: begin
							draw_color_q <= default_color;
							if (!stopped_q) begin
								if (col_adv) begin
									cur_col_q <= cur_col_q + 7'd1;
								end else if (!last_q) begin
									stopped_q <= 1'b1;
								end
							end
							if (last_q) begin
								stopped_q <= 1'b0;
							end
						end
						K_COLOR: draw_color_q <= color_q;
						K_STAND: standout_q <= so_q;
						K_EOL: begin
							swp_addr_q <= base_q[ADDR_W-1:0];
							swp_col_q  <= cur_col_q;
							swp_full_q <= 1'b0;
							if (row_ok_q && col_ok_q) begin
								state_q <= ST_CLR;
							end
						end
						K_BOT: begin
							swp_addr_q <= base_q[ADDR_W-1:0];
							swp_col_q  <= cur_col_q;
							swp_full_q <= 1'b1;
							if (row_ok_q && base_q < BASE_W'(CELLS)) begin
								state_q <= ST_CLR;
							end
						end
						K_ALL: begin
							swp_addr_q <= '0;
							swp_full_q <= 1'b1;
							cur_row_q  <= 5'd0;
							cur_col_q  <= 7'd0;
							standout_q <= 1'b0;
							state_q    <= ST_CLR;
						end
						default: ;
					endcase
				end
				ST_CLR: begin
					swp_addr_q <= swp_addr_q + ADDR_ONE;
					swp_col_q  <= swp_col_q + 7'd1;
					if (swp_end) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
